/* hw/rtl/pwt_pkg.sv */
// ============================================================================
// pwt_pkg: shared types and constants of the pulse window tachometer
// Holds the channel payloads, register indexes, status codes and the fixed
// microseconds-per-minute scale in Q.8.
// ============================================================================
package pwt_pkg;

    // Field widths of the channels and registers
    localparam int TIME_W    = 48;
    localparam int RPM_W     = 40;
    localparam int ST_W      = 2;
    localparam int PPR_W     = 8;
    localparam int STALE_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Dividend width: (WINDOW-1) * 60e6 * 256 stays below 2^40 for WINDOW up to 64,
    // so the quotient always fits the rpm field without saturation
    localparam int NUM_W = 40;

    // 60,000,000 us per minute, scaled by 256 for the Q.8 result
    localparam logic [33:0] US_PER_MIN_Q8 = 34'd15360000000;

    // Operation codes
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PPR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE = 2'd1;

    // Register reset values
    localparam logic [PPR_W-1:0]   PPR_RESET   = 8'd1;
    localparam logic [STALE_W-1:0] STALE_RESET = 32'd500000;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FEW   = 2'd1;
    localparam logic [ST_W-1:0] ST_STALE = 2'd2;
    localparam logic [ST_W-1:0] ST_SPAN  = 2'd3;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic [RPM_W-1:0] rpm_q8;
        logic [ST_W-1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [PPR_W-1:0]   ppr;
        logic [STALE_W-1:0] stale_limit;
    } t_cfg;

endpackage

/* hw/rtl/pulse_window_tachometer_top.sv */
// A pulse edge is written into the ring and yields no result; a query passes through
//   the ring read, the queue and the back end; with status ok it also runs the multiply
//   and the 40-step divide. The back end takes one query at a time; pulses are taken
//   every cycle while the queue has room and no query ring read is outstanding.
// Reset: synchronous, active low; clears ring pointer, count, queue, registers.
// The ring contents are not cleared; unwritten entries only reach queries with too few pulses.
// ============================================================================
// pulse_window_tachometer_top: pulse-period tachometer over a sliding window
// Front end records pulse edges and gathers query operands; back end divides
// out the speed in rpm (Q.8) and reports status.
// ============================================================================
module pulse_window_tachometer_top #(
    parameter int WINDOW    = 8,
    parameter int TIME_BITS = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  pwt_pkg::t_in_item                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output pwt_pkg::t_out_item                o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pwt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pwt_pkg::STALE_W-1:0]       i_cfg_data
);
    import pwt_pkg::*;

    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int ENTRY_W = CNT_W + 3 * TIME_BITS;
    localparam int Q_DEPTH = 2;

    t_cfg               r_cfg;
    t_q_stat            q_stat;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppr         <= PPR_RESET;
            r_cfg.stale_limit <= STALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PPR:   r_cfg.ppr         <= PPR_W'(i_cfg_data);
                REG_STALE: r_cfg.stale_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pwt_front #(
        .WINDOW    (WINDOW),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_entry    (q_wdata)
    );

    pwt_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    pwt_back #(
        .WINDOW    (WINDOW),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .i_entry     (q_rdata),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

/* hw/rtl/pwt_ram.sv */
// ============================================================================
// pwt_ram: generic single-write, dual-read RAM
// One write port and two read ports, read data registered.
// ============================================================================
module pwt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* hw/rtl/pwt_fifo.sv */
// ============================================================================
// pwt_fifo: short query queue between front and back
// Register-based FIFO; push is never issued while full, pop never while empty.
// ============================================================================
module pwt_fifo #(
    parameter int WIDTH = 180,
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output pwt_pkg::t_q_stat     o_stat
);
    import pwt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    // Store entry on push
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + AW'(1));
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + AW'(1));
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + CW'(1));
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - CW'(1));
            end
        end
    end

endmodule

/* hw/rtl/pwt_front.sv */
// ============================================================================
// pwt_front: input classifier and pulse ring
// Records pulse edges in the timestamp ring; for a query, reads the newest
// and oldest timestamps and queues them with the query time and pulse count.
// ============================================================================
module pwt_front #(
    parameter int WINDOW    = 8,
    parameter int TIME_BITS = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  pwt_pkg::t_in_item        i_in_data,
    output logic                     o_in_stall,
    input  pwt_pkg::t_q_stat         i_q_stat,
    output logic                     o_push,
    output logic [$clog2(WINDOW+1)+3*TIME_BITS-1:0] o_entry
);
    import pwt_pkg::*;

    localparam int AW    = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SW    = AW + 2;

    logic [AW-1:0]        r_slot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    logic [TIME_BITS-1:0] r_now;
    logic [CNT_W-1:0]     r_qcnt;
    logic                 in_fire;
    logic                 is_pulse;
    logic [TIME_BITS-1:0] t_in;
    logic [AW-1:0]        addr_newest;
    logic [AW-1:0]        addr_oldest;
    logic [SW-1:0]        back_sum;
    logic [TIME_BITS-1:0] rd_newest;
    logic [TIME_BITS-1:0] rd_oldest;

    // Hold input while a ring read is outstanding or the queue is full
    assign o_in_stall = r_pend || i_q_stat.full;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign is_pulse   = (i_in_data.op == OP_PULSE);
    assign t_in       = TIME_BITS'(i_in_data.time_us);

    // Ring positions of the newest and oldest valid entries
    assign addr_newest = (r_slot == '0) ? AW'(WINDOW - 1) : AW'(r_slot - AW'(1));
    assign back_sum    = SW'(SW'(r_slot) + SW'(WINDOW) - SW'(r_cnt));
    assign addr_oldest = (back_sum >= SW'(WINDOW)) ? AW'(back_sum - SW'(WINDOW))
                                                   : AW'(back_sum);

    pwt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (in_fire && is_pulse),
        .i_waddr   (r_slot),
        .i_wdata   (t_in),
        .i_raddr_a (addr_newest),
        .i_raddr_b (addr_oldest),
        .o_rdata_a (rd_newest),
        .o_rdata_b (rd_oldest)
    );

    // Advance write slot and saturating count; flag a query read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= in_fire && !is_pulse;
            if (in_fire && is_pulse) begin
                r_slot <= (r_slot == AW'(WINDOW - 1)) ? '0 : AW'(r_slot + AW'(1));
                if (r_cnt != CNT_W'(WINDOW)) begin
                    r_cnt <= CNT_W'(r_cnt + CNT_W'(1));
                end
            end
        end
    end

    // Capture query time and pulse count
    always_ff @(posedge i_clk) begin
        if (in_fire && !is_pulse) begin
            r_now  <= t_in;
            r_qcnt <= r_cnt;
        end
    end

    // Queue the query once the ring data is back
    assign o_push  = r_pend;
    assign o_entry = {r_qcnt, r_now, rd_newest, rd_oldest};

endmodule

/* hw/rtl/pwt_back.sv */
// ============================================================================
// pwt_back: query execution unit
// Checks status, forms dividend and divisor, runs a restoring divider one
// quotient bit per cycle, and holds the result in an output register.
// ============================================================================
module pwt_back #(
    parameter int WINDOW    = 8,
    parameter int TIME_BITS = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pwt_pkg::t_cfg            i_cfg,
    input  pwt_pkg::t_q_stat         i_q_stat,
    input  logic [$clog2(WINDOW+1)+3*TIME_BITS-1:0] i_entry,
    output logic                     o_pop,
    output logic                     o_out_valid,
    output pwt_pkg::t_out_item       o_out_data,
    input  logic                     i_out_stall
);
    import pwt_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DEN_W  = TIME_BITS + PPR_W;
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_newest;
    logic [TIME_BITS-1:0] r_oldest;
    logic [TIME_BITS-1:0] r_span;
    logic [ST_W-1:0]      r_status;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [ST_W-1:0]      status_chk;
    logic [TIME_BITS-1:0] age;
    logic [PPR_W-1:0]     ppr_eff;
    logic [DEN_W-1:0]     den_prod;
    logic [NUM_W-1:0]     num_prod;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 rem_ge;
    logic                 out_free;

    // Classify the query: too few pulses, stale, then span not positive
    assign age = TIME_BITS'(r_now - r_newest);
    always_comb begin
        if (r_cnt < CNT_W'(2)) begin
            status_chk = ST_FEW;
        end else if ((r_now > r_newest) && (age > TIME_BITS'(i_cfg.stale_limit))) begin
            status_chk = ST_STALE;
        end else if (r_newest <= r_oldest) begin
            status_chk = ST_SPAN;
        end else begin
            status_chk = ST_OK;
        end
    end

    // Dividend (count-1) * 60e6 * 256 and divisor ppr * span, a ppr of zero taken as one
    assign ppr_eff  = (i_cfg.ppr == '0) ? PPR_W'(1) : i_cfg.ppr;
    assign den_prod = DEN_W'({{TIME_BITS{1'b0}}, ppr_eff} * {{PPR_W{1'b0}}, r_span});
    assign num_prod = NUM_W'(NUM_W'(CNT_W'(r_cnt - CNT_W'(1))) * NUM_W'(US_PER_MIN_Q8));

    // One restoring divide step
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_den});
    assign rem_sub = (DEN_W + 1)'(rem_sh - {1'b0, r_den});

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;

    // Sequence one query
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (status_chk == ST_OK) ? S_MUL : S_OUT;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                {r_cnt, r_now, r_newest, r_oldest} <= i_entry;
            end
            S_CHECK: begin
                r_status <= status_chk;
                r_span   <= TIME_BITS'(r_newest - r_oldest);
            end
            S_MUL: begin
                r_num  <= num_prod;
                r_den  <= den_prod;
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= rem_ge ? DEN_W'(rem_sub) : DEN_W'(rem_sh);
                r_num  <= {r_num[NUM_W-2:0], rem_ge};
                r_step <= STEP_W'(r_step + STEP_W'(1));
            end
            S_OUT: begin
                if (out_free) begin
                    r_out.status <= r_status;
                    r_out.rpm_q8 <= (r_status == ST_OK) ? RPM_W'(r_num) : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/pwt_checker.sv */
// ============================================================================
// pwt_checker: port-level checks for the tachometer top level
// Watches the channels over time; attached to the top level by bind.
// ============================================================================
module pwt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input pwt_pkg::t_in_item             i_in_data,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input pwt_pkg::t_out_item            o_out_data,
    input logic                          i_out_stall
);
    import pwt_pkg::*;

    // No result is shown right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A non-ok status always carries zero speed
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.rpm_q8 == '0))
        else $error("nonzero speed with error status");

    // An accepted query holds the input for its ring read
    a_query_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.op == OP_QUERY)) |=> o_in_stall)
        else $error("input taken during query ring read");

    // Stalled result stays valid
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind pulse_window_tachometer_top pwt_checker u_pwt_checker (.*);

/* bench/tb_pulse_window_tachometer_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_pulse_window_tachometer_top: self-checking bench for the tachometer
// Sends pulse edges and speed queries over the stall handshake, tracks the
// pulse ring and registers in a local copy, and checks every speed reading
// field by field. Several register settings and idle profiles are covered.
// ============================================================================
module tb_pulse_window_tachometer_top;
    import pwt_pkg::*;

    localparam int          WINDOW       = 8;
    localparam int          TAIL_CYCLES  = 60;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          PHASE_ITEMS  = 210;
    localparam logic [63:0] RPM_LIMIT    = (64'd1 << RPM_W) - 64'd1;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;
    // index outside the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_feed_entry;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_item             in_data = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STALE_W-1:0]   cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 o_cfg_ready;

    // Stimulus and reading stores
    t_feed_entry items_to_send[$];
    t_out_item   readings_due[$];
    logic        all_read = 1'b1;
    int unsigned tx_idle_pct = 9;
    int unsigned rx_stall_pct = 45;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // Local copy of the ring and the registers
    logic [TIME_W-1:0]  edge_times[WINDOW];
    int                 edge_slot = 0;
    int                 edge_count = 0;
    logic [PPR_W-1:0]   cfg_ppr = PPR_RESET;
    logic [STALE_W-1:0] cfg_stale = STALE_RESET;

    // Random pulse train state
    logic [TIME_W-1:0] track_us = '0;
    int unsigned       gap_lo = 1;
    int unsigned       gap_hi = 1000;

    pulse_window_tachometer_top #(
        .WINDOW   (WINDOW),
        .TIME_BITS(TIME_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Record a pulse in the ring, or work out the reading a query must return
    function automatic void account_item(input t_in_item it);
        logic [TIME_W-1:0] newest;
        logic [TIME_W-1:0] oldest;
        logic [TIME_W-1:0] span;
        logic [63:0]       scaled;
        logic [63:0]       quot;
        t_out_item         reading;
        reading = '0;
        if (it.op == OP_PULSE) begin
            edge_times[edge_slot] = it.time_us;
            edge_slot = (edge_slot + 1) % WINDOW;
            if (edge_count < WINDOW) edge_count++;
            return;
        end
        if (edge_count < 2) begin
            reading.status = ST_FEW;
        end else begin
            newest = edge_times[(edge_slot + WINDOW - 1) % WINDOW];
            oldest = edge_times[(edge_slot + WINDOW - edge_count) % WINDOW];
            // a query earlier than the newest pulse has zero age
            if (it.time_us > newest && (it.time_us - newest) > TIME_W'(cfg_stale)) begin
                reading.status = ST_STALE;
            end else if (newest <= oldest) begin
                reading.status = ST_SPAN;
            end else begin
                span   = newest - oldest;
                scaled = 64'(edge_count - 1) * 64'(US_PER_MIN_Q8);
                scaled = scaled / ((cfg_ppr == '0) ? 64'd1 : 64'(cfg_ppr));
                quot   = scaled / 64'(span);
                reading.rpm_q8 = (quot > RPM_LIMIT) ? RPM_LIMIT[RPM_W-1:0] : quot[RPM_W-1:0];
                reading.status = ST_OK;
            end
        end
        readings_due.push_back(reading);
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] got,
                                          input logic [63:0] want);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
    endfunction

    function automatic void queue_item(input logic op, input logic [TIME_W-1:0] t,
                                       input bit drain);
        t_feed_entry e;
        e.item.op      = op;
        e.item.time_us = t;
        e.drain        = drain;
        items_to_send.push_back(e);
    endfunction

    function automatic logic [TIME_W-1:0] any_time();
        return {16'($urandom()), $urandom()};
    endfunction

    // Driver: present queued transactions, idle at random, hold for drains
    always @(posedge i_clk) begin
        t_feed_entry next_entry;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (items_to_send.size() == 0 || $urandom_range(99) < tx_idle_pct) begin
                in_valid <= 1'b0;
            end else if (items_to_send[0].drain && (in_valid || !all_read)) begin
                in_valid <= 1'b0;
            end else begin
                next_entry = items_to_send.pop_front();
                in_valid <= 1'b1;
                in_data  <= next_entry.item;
            end
        end
    end

    // Monitor: predict on accepted inputs, check readings, drive the output stall
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            all_read  <= 1'b1;
        end else begin
            if (in_valid && !o_in_stall) account_item(in_data);
            if (o_out_valid && !out_stall) begin
                if (readings_due.size() == 0) begin
                    flag_mismatch("unexpected reading", 64'(o_out_data), 64'd0);
                end else begin
                    want = readings_due.pop_front();
                    if (o_out_data.rpm_q8 !== want.rpm_q8)
                        flag_mismatch("rpm_q8", 64'(o_out_data.rpm_q8), 64'(want.rpm_q8));
                    if (o_out_data.status !== want.status)
                        flag_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                end
            end
            all_read  <= (readings_due.size() == 0);
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL pulse_window_tachometer_top");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STALE_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_PPR) cfg_ppr = data[PPR_W-1:0];
        else if (idx == REG_STALE) cfg_stale = data;
    endtask

    // Wait until every transaction is in and read back, then let the pipe drain
    task automatic wait_quiet();
        @(negedge i_clk);
        while (items_to_send.size() != 0 || in_valid || readings_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Mostly steady pulse trains with queries, plus noise and broken timing
    task automatic plan_phase(input int unsigned n, input int unsigned tx,
                              input int unsigned rx);
        int unsigned       pushed;
        int unsigned       r;
        logic [TIME_W-1:0] t;
        pushed = 0;
        @(negedge i_clk);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        while (pushed < n) begin
            if (pushed == 0 || $urandom_range(19) == 0) begin
                case ($urandom_range(3))
                    0: begin gap_lo = 0; gap_hi = 2; end
                    1: begin gap_lo = 2; gap_hi = 1000; end
                    2: begin gap_lo = 1000; gap_hi = 200000; end
                    default: begin gap_lo = 200000; gap_hi = 1 << 26; end
                endcase
            end
            r = $urandom_range(99);
            if (r < 12) begin
                queue_item(1'($urandom()), any_time(), 1'b0);
                pushed++;
            end else if (r < 20) begin
                // pulse that repeats or steps back in time
                queue_item(OP_PULSE, track_us - TIME_W'($urandom_range(0, 5000)), 1'b0);
                pushed++;
            end else if (r < 22) begin
                // jump close to the top of the time range so the train wraps
                track_us = TIME_TOP - TIME_W'($urandom_range(0, 20000));
            end else begin
                track_us = track_us + TIME_W'($urandom_range(gap_lo, gap_hi));
                queue_item(OP_PULSE, track_us, 1'b0);
                pushed++;
                if ($urandom_range(99) < 45) begin
                    case ($urandom_range(7))
                        0, 1: t = track_us;
                        2, 3: t = track_us + TIME_W'($urandom_range(0, gap_hi));
                        4: t = track_us + TIME_W'(cfg_stale);
                        5: t = track_us + TIME_W'(cfg_stale) + 1'b1;
                        6: t = track_us - TIME_W'($urandom_range(1, 1000));
                        default: t = any_time();
                    endcase
                    queue_item(OP_QUERY, t, (pushed == n / 2) || ($urandom_range(99) == 0));
                    pushed++;
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset register values
        @(negedge i_clk);
        queue_item(OP_QUERY, '0, 1'b0);                  // no pulses yet
        queue_item(OP_PULSE, 48'd1000, 1'b0);
        queue_item(OP_QUERY, 48'd1000, 1'b0);            // one pulse only
        queue_item(OP_PULSE, 48'd1000, 1'b0);
        queue_item(OP_QUERY, 48'd1000, 1'b0);            // zero span
        queue_item(OP_PULSE, 48'd500, 1'b0);
        queue_item(OP_QUERY, '0, 1'b0);                  // earlier query, newest below oldest
        queue_item(OP_QUERY, TIME_TOP, 1'b1);            // stale
        queue_item(OP_PULSE, 48'd1500, 1'b0);
        queue_item(OP_QUERY, 48'd501500, 1'b0);          // age exactly at the limit
        queue_item(OP_QUERY, 48'd501501, 1'b0);          // one past the limit
        queue_item(OP_QUERY, 48'd100, 1'b0);             // query before newest pulse
        for (int k = 1; k <= 5; k++) queue_item(OP_PULSE, TIME_W'(1500 + k), 1'b0);
        queue_item(OP_QUERY, 48'd1505, 1'b0);            // full, wrapped window
        queue_item(OP_PULSE, TIME_TOP, 1'b0);
        queue_item(OP_QUERY, TIME_TOP, 1'b0);            // widest span
        queue_item(OP_PULSE, '0, 1'b0);
        queue_item(OP_QUERY, '0, 1'b0);                  // time wrapped to zero
        wait_quiet();

        write_reg(REG_PPR, '0);
        write_reg(REG_STALE, '0);
        write_reg(REG_SPARE, $urandom());
        plan_phase(PHASE_ITEMS, 9, 45);
        wait_quiet();

        write_reg(REG_PPR, 32'd255);
        write_reg(REG_STALE, '1);
        plan_phase(PHASE_ITEMS, 45, 9);
        wait_quiet();

        write_reg(REG_PPR, 32'($urandom_range(0, 255)));
        write_reg(REG_STALE, $urandom());
        plan_phase(PHASE_ITEMS, 0, 0);
        wait_quiet();

        write_reg(REG_PPR, 32'($urandom_range(1, 12)));
        write_reg(REG_STALE, 32'($urandom_range(1000, 2000000)));
        plan_phase(PHASE_ITEMS, 0, 0);
        wait_quiet();

        if (fail_count == 0 && readings_due.size() == 0) begin
            $display("PASS pulse_window_tachometer_top");
        end else begin
            $display("FAIL pulse_window_tachometer_top");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/pwt_pkg.sv
hw/rtl/pwt_ram.sv
hw/rtl/pwt_fifo.sv
hw/rtl/pwt_front.sv
hw/rtl/pwt_back.sv
hw/rtl/pulse_window_tachometer_top.sv
hw/rtl/pwt_checker.sv
bench/tb_pulse_window_tachometer_top.sv
